// File: sv/lzbu_pkg.sv
// lzbu_pkg: shared constants, types and helpers for the lz bitstream unpacker
// depends on nothing
`default_nettype none
package lzbu_pkg;
    localparam int HIST_AW = 16;

    localparam logic [1:0] ST_BYTE = 2'd0;
    localparam logic [1:0] ST_MORE = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;
    localparam logic [1:0] ST_ERR  = 2'd3;

    localparam logic [3:0] PH_FLAG   = 4'd0;
    localparam logic [3:0] PH_LIT    = 4'd1;
    localparam logic [3:0] PH_TYPE   = 4'd2;
    localparam logic [3:0] PH_WSEL   = 4'd3;
    localparam logic [3:0] PH_WDIST  = 4'd4;
    localparam logic [3:0] PH_DCLS   = 4'd5;
    localparam logic [3:0] PH_DEXTRA = 4'd6;
    localparam logic [3:0] PH_DBITS  = 4'd7;
    localparam logic [3:0] PH_LEN1   = 4'd8;
    localparam logic [3:0] PH_LEN0   = 4'd9;
    localparam logic [3:0] PH_LEN3   = 4'd10;
    localparam logic [3:0] PH_LEN4   = 4'd11;
    localparam logic [3:0] PH_LENU   = 4'd12;
    localparam logic [3:0] PH_LENV   = 4'd13;

    // controller -> datapath commands
    typedef struct packed {
        logic deliver;    // shift an input byte into the bit store
        logic step;       // do one decode step
        logic rd_start;   // issue history read for copy
        logic copy_emit;  // write read data to history, count down
    } lzbu_cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic       running;
        logic       ended;
        logic       input_ended;
        logic       store_full;
        logic       copying;
        logic       emit;
        logic       starve;
        logic [7:0] emit_byte;
    } lzbu_stat_t;

    function automatic logic [15:0] block_base(input logic [3:0] n);
        logic [16:0] p;
        begin
            p = 17'd1 << n;
            if (n == 4'd14) block_base = 16'h1fe1;
            else if (n == 4'd15) block_base = 16'h5fe1;
            else block_base = p[15:0] - 16'd31;
        end
    endfunction
endpackage
`default_nettype wire

// File: sv/lzbu_datapath.sv
// lzbu_datapath: bit store, decode step logic, copy engine and history memory
// depends on lzbu_pkg
`default_nettype none
module lzbu_datapath (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire lzbu_pkg::lzbu_cmd_t cmd,
    input  wire logic [7:0]        in_byte,
    input  wire logic              in_last,
    output lzbu_pkg::lzbu_stat_t   stat
);
    localparam logic [1:0] SS_RUN = 2'd0;
    localparam logic [1:0] SS_END = 2'd1;
    localparam logic [1:0] SS_ERR = 2'd2;

    logic [31:0] store_reg;
    logic [5:0]  count_reg;
    logic        ended_in_reg;
    logic [3:0]  phase_reg;
    logic [15:0] pval_reg;
    logic [3:0]  lcls_reg;
    logic [15:0] dist_reg;
    logic [13:0] rem_reg;
    logic [15:0] wp_reg;
    logic [16:0] prod_reg;
    logic [1:0]  sst_reg;
    logic [7:0]  rd_reg;
    logic [7:0]  hist [0:(2**lzbu_pkg::HIST_AW)-1];

    logic [4:0]  need;
    logic        have;
    logic [15:0] v;
    logic [31:0] sh;
    logic        lit_emit;
    logic [15:0] cd_next;

    // bits needed by the current phase
    always_comb
    begin
        case (phase_reg)
            lzbu_pkg::PH_LIT:  need = 5'd8;
            lzbu_pkg::PH_TYPE, lzbu_pkg::PH_WSEL: need = 5'd2;
            lzbu_pkg::PH_WDIST, lzbu_pkg::PH_DBITS: need = {1'b0, pval_reg[3:0]};
            lzbu_pkg::PH_DCLS, lzbu_pkg::PH_LEN3: need = 5'd3;
            lzbu_pkg::PH_LEN4: need = 5'd4;
            lzbu_pkg::PH_LENU: need = (lcls_reg == 4'd7) ? 5'd0 : 5'd1;
            lzbu_pkg::PH_LENV: need = {1'b0, lcls_reg};
            default: need = 5'd1;
        endcase
        have = {1'b0, count_reg} >= {2'b0, need};
        sh = store_reg >> (count_reg - {1'b0, need});
        v = sh[15:0] & ((16'd1 << need) - 16'd1);
    end

    assign lit_emit = cmd.step && have && phase_reg == lzbu_pkg::PH_LIT;
    assign cd_next = lzbu_pkg::block_base(pval_reg[3:0]) + v;

    assign stat.running     = sst_reg == SS_RUN;
    assign stat.ended       = sst_reg == SS_END;
    assign stat.input_ended = ended_in_reg;
    assign stat.store_full  = count_reg > 6'd24;
    assign stat.copying     = rem_reg != 14'd0;
    assign stat.emit        = have && phase_reg == lzbu_pkg::PH_LIT;
    assign stat.starve      = !have;
    assign stat.emit_byte   = (rem_reg != 14'd0) ? rd_reg : v[7:0];

    always_ff @(posedge clk)
    begin
        if (cmd.rd_start)
            rd_reg <= hist[wp_reg - dist_reg];
        if (cmd.copy_emit)
            hist[wp_reg] <= rd_reg;
        else if (lit_emit)
            hist[wp_reg] <= v[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [16:0] dcmp;
        logic [15:0] wb;
        if (!rst_n)
        begin
            store_reg <= '0; count_reg <= '0; ended_in_reg <= 1'b0;
            phase_reg <= lzbu_pkg::PH_FLAG; pval_reg <= '0; lcls_reg <= '0;
            dist_reg <= '0; rem_reg <= '0; wp_reg <= '0; prod_reg <= '0;
            sst_reg <= SS_RUN;
        end
        else
        begin
            if (cmd.deliver)
            begin
                if (count_reg > 6'd24)
                    sst_reg <= SS_ERR;
                else
                begin
                    store_reg <= {store_reg[23:0], in_byte};
                    count_reg <= count_reg + 6'd8;
                    ended_in_reg <= in_last;
                end
            end
            if (cmd.copy_emit || lit_emit)
            begin
                wp_reg <= wp_reg + 16'd1;
                if (prod_reg < 17'd65536)
                    prod_reg <= prod_reg + 17'd1;
            end
            if (cmd.copy_emit)
                rem_reg <= rem_reg - 14'd1;
            if (cmd.step && !have && ended_in_reg)
                sst_reg <= SS_ERR;
            if (cmd.step && have)
            begin
                count_reg <= count_reg - {1'b0, need};
                case (phase_reg)
                    lzbu_pkg::PH_LIT: phase_reg <= lzbu_pkg::PH_FLAG;
                    lzbu_pkg::PH_TYPE:
                        if (v[1:0] == 2'd3) phase_reg <= lzbu_pkg::PH_WSEL;
                        else
                        begin
                            lcls_reg <= {2'b0, v[1:0]};
                            phase_reg <= lzbu_pkg::PH_DCLS;
                        end
                    lzbu_pkg::PH_WSEL:
                    begin
                        pval_reg <= v[1] ? v + 16'd6 : v + 16'd5;
                        phase_reg <= lzbu_pkg::PH_WDIST;
                    end
                    lzbu_pkg::PH_WDIST:
                    begin
                        wb = (16'd1 << pval_reg[3:0])
                             - ((pval_reg[3:0] <= 4'd6) ? 16'd31 : 16'd159);
                        phase_reg <= lzbu_pkg::PH_FLAG;
                        if (v == 16'h1ff) sst_reg <= SS_END;
                        else
                        begin
                            dcmp = {1'b0, wb + v};
                            if (dcmp > prod_reg) sst_reg <= SS_ERR;
                            else begin dist_reg <= dcmp[15:0]; rem_reg <= 14'd2; end
                        end
                    end
                    lzbu_pkg::PH_DCLS:
                    begin
                        case (v[2:0])
                            3'd3:
                            begin
                                pval_reg <= 16'd8; phase_reg <= lzbu_pkg::PH_DEXTRA;
                            end
                            3'd4:
                            begin
                                pval_reg <= 16'd10; phase_reg <= lzbu_pkg::PH_DEXTRA;
                            end
                            3'd5:
                            begin
                                pval_reg <= 16'd12; phase_reg <= lzbu_pkg::PH_DBITS;
                            end
                            3'd6:
                            begin
                                pval_reg <= 16'h0e; phase_reg <= lzbu_pkg::PH_DBITS;
                            end
                            3'd7:
                            begin
                                pval_reg <= 16'h0f; phase_reg <= lzbu_pkg::PH_DBITS;
                            end
                            default:
                            begin
                                pval_reg <= v + 16'd5; phase_reg <= lzbu_pkg::PH_DBITS;
                            end
                        endcase
                    end
                    lzbu_pkg::PH_DEXTRA:
                    begin
                        pval_reg <= pval_reg + v;
                        phase_reg <= lzbu_pkg::PH_DBITS;
                    end
                    lzbu_pkg::PH_DBITS:
                    begin
                        dist_reg <= cd_next;
                        if (lcls_reg != 4'd0)
                        begin
                            phase_reg <= lzbu_pkg::PH_FLAG;
                            if ({1'b0, cd_next} > prod_reg) sst_reg <= SS_ERR;
                            else rem_reg <= {10'd0, lcls_reg} + 14'd2;
                        end
                        else phase_reg <= lzbu_pkg::PH_LEN1;
                    end
                    lzbu_pkg::PH_LEN1:
                        phase_reg <= v[0] ? lzbu_pkg::PH_LEN3 : lzbu_pkg::PH_LEN0;
                    lzbu_pkg::PH_LEN0:
                    begin
                        phase_reg <= lzbu_pkg::PH_FLAG;
                        if ({1'b0, dist_reg} > prod_reg) sst_reg <= SS_ERR;
                        else rem_reg <= v[13:0] + 14'd5;
                    end
                    lzbu_pkg::PH_LEN3:
                        if (v != 16'd0)
                        begin
                            phase_reg <= lzbu_pkg::PH_FLAG;
                            if ({1'b0, dist_reg} > prod_reg) sst_reg <= SS_ERR;
                            else rem_reg <= v[13:0] + 14'd6;
                        end
                        else phase_reg <= lzbu_pkg::PH_LEN4;
                    lzbu_pkg::PH_LEN4:
                        if (v != 16'd0)
                        begin
                            phase_reg <= lzbu_pkg::PH_FLAG;
                            if ({1'b0, dist_reg} > prod_reg) sst_reg <= SS_ERR;
                            else rem_reg <= v[13:0] + 14'd13;
                        end
                        else
                        begin
                            lcls_reg <= 4'd4; pval_reg <= 16'h0d;
                            phase_reg <= lzbu_pkg::PH_LENU;
                        end
                    lzbu_pkg::PH_LENU:
                        if (lcls_reg == 4'd7)
                        begin
                            lcls_reg <= 4'he; pval_reg <= '0;
                            phase_reg <= lzbu_pkg::PH_LENV;
                        end
                        else
                        begin
                            pval_reg <= ((pval_reg + 16'd2) << 1) - 16'd1;
                            lcls_reg <= lcls_reg + 4'd1;
                            if (v[0]) phase_reg <= lzbu_pkg::PH_LENV;
                        end
                    lzbu_pkg::PH_LENV:
                    begin
                        phase_reg <= lzbu_pkg::PH_FLAG;
                        if ({1'b0, dist_reg} > prod_reg) sst_reg <= SS_ERR;
                        else rem_reg <= v[13:0] + pval_reg[13:0];
                    end
                    default:
                        phase_reg <= v[0] ? lzbu_pkg::PH_TYPE : lzbu_pkg::PH_LIT;
                endcase
            end
        end
    end
endmodule
`default_nettype wire

// File: sv/lzbu_ctrl.sv
// lzbu_ctrl: request sequencer and output register for the unpacker
// depends on lzbu_pkg
`default_nettype none
module lzbu_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic                 kind,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [7:0]                out_byte,
    output logic [1:0]                status,
    output lzbu_pkg::lzbu_cmd_t       cmd,
    input  wire lzbu_pkg::lzbu_stat_t stat
);
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DEC  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;
    logic [7:0] ob_reg, ob_next;
    logic [1:0] os_reg, os_next;
    logic       acc;
    logic       slot;

    assign slot = !ov_reg || out_ready;
    assign in_ready = state_reg == S_IDLE && slot;
    assign acc = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_byte = ob_reg;
    assign status = os_reg;

    always_comb
    begin
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        ob_next = ob_reg;
        os_next = os_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE:
                if (acc)
                begin
                    if (!kind)
                    begin
                        if (stat.running && !stat.input_ended)
                        begin
                            cmd.deliver = 1'b1;
                            if (stat.store_full)
                            begin
                                ov_next = 1'b1; ob_next = 8'd0;
                                os_next = lzbu_pkg::ST_ERR;
                            end
                        end
                    end
                    else state_next = S_DEC;
                end
            S_DEC:
                // one decode step a cycle until a byte, end, error or starve
                if (!stat.running)
                begin
                    ov_next = 1'b1; ob_next = 8'd0;
                    os_next = stat.ended ? lzbu_pkg::ST_END : lzbu_pkg::ST_ERR;
                    state_next = S_IDLE;
                end
                else if (stat.copying)
                begin
                    cmd.rd_start = 1'b1;
                    state_next = S_RD;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (stat.emit)
                    begin
                        ov_next = 1'b1; ob_next = stat.emit_byte;
                        os_next = lzbu_pkg::ST_BYTE;
                        state_next = S_IDLE;
                    end
                    else if (stat.starve && !stat.input_ended)
                    begin
                        ov_next = 1'b1; ob_next = 8'd0;
                        os_next = lzbu_pkg::ST_MORE;
                        state_next = S_IDLE;
                    end
                end
            S_RD:
            begin
                cmd.copy_emit = 1'b1;
                ov_next = 1'b1; ob_next = stat.emit_byte;
                os_next = lzbu_pkg::ST_BYTE;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ob_reg <= ob_next;
        os_reg <= os_next;
    end
endmodule
`default_nettype wire

// File: sv/lz_bitstream_unpacker.sv
// lz_bitstream_unpacker: lz77 bit-code decompressor, byte in, byte per pull out
// a delivered byte goes straight into the bit store; a pull is accepted, then runs decode
// steps until a result, and a copied byte waits on a registered history read
// a literal is two decode steps; other tokens add one step per code field read
// reset: asynchronous active low clears control state; history is not cleared
`default_nettype none
module lz_bitstream_unpacker (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] in_byte,
    input  wire logic       in_last,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      out_byte,
    output logic [1:0]      status
);
    lzbu_pkg::lzbu_cmd_t  cmd;
    lzbu_pkg::lzbu_stat_t stat;

    // sequencer: takes requests, drives decode steps, holds the result
    lzbu_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .kind(kind),
        .out_valid(out_valid), .out_ready(out_ready),
        .out_byte(out_byte), .status(status),
        .cmd(cmd), .stat(stat)
    );

    // bit store, token decoder, copy engine, history
    lzbu_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .in_byte(in_byte), .in_last(in_last), .stat(stat)
    );
endmodule
`default_nettype wire

// File: dv/tb_top.sv
// tb_top: self-checking bench for lz_bitstream_unpacker, one long compressed stream
// depends on lzbu_pkg and lz_bitstream_unpacker; builds its own encoder and decoder model
`default_nettype none
module tb_top;
    localparam int HDEPTH = 65536;
    localparam int N_ITEMS = 1450;
    localparam int RUN_OK = 0;
    localparam int RUN_DONE = 1;
    localparam int RUN_FAIL = 2;
    localparam int TERM_END = 0;
    localparam int TERM_BAD_DIST = 1;
    localparam int TERM_OVERFILL = 2;
    localparam int TERM_STARVE = 3;

    typedef struct {
        bit k;
        logic [7:0] b;
        bit last;
    } request_t;

    typedef struct {
        logic [7:0] b;
        logic [1:0] st;
    } answer_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic kind;
    logic [7:0] in_byte;
    logic in_last;
    logic out_valid;
    logic out_ready;
    logic [7:0] out_byte;
    logic [1:0] status;

    // two decoder copies: 0 follows the dut, 1 steers the stimulus builder
    logic [31:0] d_store[2];
    int unsigned d_cnt[2];
    bit d_ended[2];
    logic [3:0] d_ph[2];
    int unsigned d_pv[2];
    int unsigned d_lc[2];
    int unsigned d_dist[2];
    int unsigned d_rem[2];
    logic [7:0] d_hist[2][HDEPTH];
    int unsigned d_wp[2];
    int unsigned d_prod[2];
    int d_run[2];

    request_t stim_q[$];
    answer_t expected_q[$];
    bit enc_bits[$];
    int unsigned enc_prod;
    int acc_cnt;
    int res_cnt;
    int fail_cnt;
    int term_mode;
    int hold_left;
    bit hold_done;

    lz_bitstream_unpacker u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .kind(kind),
        .in_byte(in_byte),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_byte(out_byte),
        .status(status)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------- decoder model ----------------

    function automatic int unsigned dist_base(input int unsigned n);
        if (n == 14) return 8161;
        if (n == 15) return 24545;
        return (1 << n) - 31;
    endfunction

    function automatic void model_clear(input int s);
        d_store[s] = '0;
        d_cnt[s] = 0;
        d_ended[s] = 0;
        d_ph[s] = lzbu_pkg::PH_FLAG;
        d_pv[s] = 0;
        d_lc[s] = 0;
        d_dist[s] = 0;
        d_rem[s] = 0;
        d_wp[s] = 0;
        d_prod[s] = 0;
        d_run[s] = RUN_OK;
        for (int i = 0; i < HDEPTH; i++)
            d_hist[s][i] = 8'h00;
    endfunction

    function automatic bit grab_bits(input int s, input int unsigned n, output int unsigned v);
        v = 0;
        if (d_cnt[s] < n)
            return 0;
        v = (d_store[s] >> (d_cnt[s] - n)) & ((32'd1 << n) - 1);
        d_cnt[s] -= n;
        return 1;
    endfunction

    function automatic void hist_put(input int s, input logic [7:0] b);
        d_hist[s][d_wp[s]] = b;
        d_wp[s] = (d_wp[s] + 1) % HDEPTH;
        if (d_prod[s] < HDEPTH)
            d_prod[s]++;
    endfunction

    function automatic void copy_begin(input int s, input int unsigned cdist,
                                       input int unsigned len);
        d_ph[s] = lzbu_pkg::PH_FLAG;
        if (cdist > d_prod[s])
        begin
            d_run[s] = RUN_FAIL;
            return;
        end
        d_dist[s] = cdist;
        d_rem[s] = len & 32'h3fff;
    endfunction

    // one request into decoder copy s; has tells whether an answer comes back
    task automatic unpack_step(input int s, input bit k, input logic [7:0] b, input bit last,
                               output bit has, output logic [7:0] ob, output logic [1:0] st);
        int unsigned need;
        int unsigned v;
        int unsigned w;
        int unsigned base;
        bit done;
        has = 0;
        ob = 8'h00;
        st = lzbu_pkg::ST_BYTE;
        if (!k)
        begin
            if (d_run[s] != RUN_OK || d_ended[s])
                return;
            if (d_cnt[s] > 24)
            begin
                d_run[s] = RUN_FAIL;
                has = 1;
                st = lzbu_pkg::ST_ERR;
                return;
            end
            d_store[s] = (d_store[s] << 8) | b;
            d_cnt[s] += 8;
            d_ended[s] = last;
            return;
        end
        has = 1;
        done = 0;
        while (!done)
        begin
            if (d_run[s] == RUN_DONE)
            begin
                st = lzbu_pkg::ST_END;
                done = 1;
            end
            else if (d_run[s] == RUN_FAIL)
            begin
                st = lzbu_pkg::ST_ERR;
                done = 1;
            end
            else if (d_rem[s] != 0)
            begin
                ob = d_hist[s][(d_wp[s] + HDEPTH - d_dist[s]) % HDEPTH];
                hist_put(s, ob);
                d_rem[s]--;
                done = 1;
            end
            else
            begin
                case (d_ph[s])
                    lzbu_pkg::PH_LIT: need = 8;
                    lzbu_pkg::PH_TYPE, lzbu_pkg::PH_WSEL: need = 2;
                    lzbu_pkg::PH_WDIST, lzbu_pkg::PH_DBITS: need = d_pv[s] & 15;
                    lzbu_pkg::PH_DCLS, lzbu_pkg::PH_LEN3: need = 3;
                    lzbu_pkg::PH_LEN4: need = 4;
                    lzbu_pkg::PH_LENU: need = (d_lc[s] == 7) ? 0 : 1;
                    lzbu_pkg::PH_LENV: need = d_lc[s] & 15;
                    default: need = 1;
                endcase
                v = 0;
                if (need != 0 && !grab_bits(s, need, v))
                begin
                    if (d_ended[s])
                        d_run[s] = RUN_FAIL;
                    else
                    begin
                        st = lzbu_pkg::ST_MORE;
                        done = 1;
                    end
                end
                else
                begin
                    case (d_ph[s])
                        lzbu_pkg::PH_LIT:
                        begin
                            d_ph[s] = lzbu_pkg::PH_FLAG;
                            ob = v[7:0];
                            hist_put(s, ob);
                            done = 1;
                        end
                        lzbu_pkg::PH_TYPE:
                        begin
                            if (v == 3)
                                d_ph[s] = lzbu_pkg::PH_WSEL;
                            else
                            begin
                                d_lc[s] = v;
                                d_ph[s] = lzbu_pkg::PH_DCLS;
                            end
                        end
                        lzbu_pkg::PH_WSEL:
                        begin
                            d_pv[s] = (v >= 2) ? v + 6 : v + 5;
                            d_ph[s] = lzbu_pkg::PH_WDIST;
                        end
                        lzbu_pkg::PH_WDIST:
                        begin
                            w = d_pv[s] & 15;
                            base = (1 << w) - ((w <= 6) ? 31 : 159);
                            if (v == 32'h1ff)
                            begin
                                d_run[s] = RUN_DONE;
                                d_ph[s] = lzbu_pkg::PH_FLAG;
                            end
                            else
                                copy_begin(s, base + v, 2);
                        end
                        lzbu_pkg::PH_DCLS:
                        begin
                            if (v < 3)
                            begin
                                d_pv[s] = v + 5;
                                d_ph[s] = lzbu_pkg::PH_DBITS;
                            end
                            else if (v == 3 || v == 4)
                            begin
                                d_pv[s] = (v == 3) ? 8 : 10;
                                d_ph[s] = lzbu_pkg::PH_DEXTRA;
                            end
                            else
                            begin
                                d_pv[s] = (v == 5) ? 12 : (v == 6) ? 14 : 15;
                                d_ph[s] = lzbu_pkg::PH_DBITS;
                            end
                        end
                        lzbu_pkg::PH_DEXTRA:
                        begin
                            d_pv[s] += v;
                            d_ph[s] = lzbu_pkg::PH_DBITS;
                        end
                        lzbu_pkg::PH_DBITS:
                        begin
                            d_dist[s] = (dist_base(d_pv[s] & 15) + v) & 32'hffff;
                            if (d_lc[s] != 0)
                                copy_begin(s, d_dist[s], d_lc[s] + 2);
                            else
                                d_ph[s] = lzbu_pkg::PH_LEN1;
                        end
                        lzbu_pkg::PH_LEN1:
                            d_ph[s] = (v != 0) ? lzbu_pkg::PH_LEN3 : lzbu_pkg::PH_LEN0;
                        lzbu_pkg::PH_LEN0:
                            copy_begin(s, d_dist[s], 5 + v);
                        lzbu_pkg::PH_LEN3:
                        begin
                            if (v != 0)
                                copy_begin(s, d_dist[s], v + 6);
                            else
                                d_ph[s] = lzbu_pkg::PH_LEN4;
                        end
                        lzbu_pkg::PH_LEN4:
                        begin
                            if (v != 0)
                                copy_begin(s, d_dist[s], v + 13);
                            else
                            begin
                                d_lc[s] = 4;
                                d_pv[s] = 13;
                                d_ph[s] = lzbu_pkg::PH_LENU;
                            end
                        end
                        lzbu_pkg::PH_LENU:
                        begin
                            if (d_lc[s] == 7)
                            begin
                                d_lc[s] = 14;
                                d_pv[s] = 0;
                                d_ph[s] = lzbu_pkg::PH_LENV;
                            end
                            else
                            begin
                                d_pv[s] = (((d_pv[s] + 2) << 1) - 1) & 32'hffff;
                                d_lc[s]++;
                                if (v != 0)
                                    d_ph[s] = lzbu_pkg::PH_LENV;
                            end
                        end
                        lzbu_pkg::PH_LENV:
                            copy_begin(s, d_dist[s], v + d_pv[s]);
                        default:
                            d_ph[s] = (v != 0) ? lzbu_pkg::PH_TYPE : lzbu_pkg::PH_LIT;
                    endcase
                end
            end
        end
    endtask

    // ---------------- stream encoder ----------------

    function automatic void put_bits(input int unsigned val, input int n);
        for (int i = n - 1; i >= 0; i--)
            enc_bits.push_back(val[i]);
    endfunction

    function automatic void grow_prod(input int unsigned len);
        enc_prod = (enc_prod + len > HDEPTH) ? HDEPTH : enc_prod + len;
    endfunction

    function automatic void enc_literal(input logic [7:0] b);
        put_bits(0, 1);
        put_bits(b, 8);
        grow_prod(1);
    endfunction

    // two-byte copy, distance 1..863
    function automatic void enc_word(input int unsigned cdist);
        put_bits(3'b111, 3);
        if (cdist <= 32)
        begin
            put_bits(0, 2);
            put_bits(cdist - 1, 5);
        end
        else if (cdist <= 96)
        begin
            put_bits(1, 2);
            put_bits(cdist - 33, 6);
        end
        else if (cdist <= 352)
        begin
            put_bits(2, 2);
            put_bits(cdist - 97, 8);
        end
        else
        begin
            put_bits(3, 2);
            put_bits(cdist - 353, 9);
        end
        grow_prod(2);
    endfunction

    function automatic void enc_end();
        put_bits(5'b11111, 5);
        put_bits(9'h1ff, 9);
    endfunction

    // block copy; long_form forces the 14-bit length code
    function automatic void enc_block(input int unsigned cdist, input int unsigned len,
                                      input bit long_form);
        int unsigned n;
        int unsigned cls;
        n = 5;
        while (cdist >= dist_base(n) + (1 << n))
            n = (n == 12) ? 14 : n + 1;
        put_bits(1, 1);
        if ((len == 3 || len == 4) && !long_form)
            put_bits(len - 2, 2);
        else
            put_bits(0, 2);
        if (n <= 7) cls = n - 5;
        else if (n <= 9) cls = 3;
        else if (n <= 11) cls = 4;
        else if (n == 12) cls = 5;
        else if (n == 14) cls = 6;
        else cls = 7;
        put_bits(cls, 3);
        if (cls == 3 || cls == 4)
            put_bits(n & 1, 1);
        put_bits(cdist - dist_base(n), n);
        if (!((len == 3 || len == 4) && !long_form))
        begin
            if (long_form || len < 5 || len > 252)
            begin
                put_bits(11'b10000000000, 11);
                put_bits(len, 14);
            end
            else if (len <= 6)
                put_bits({1'b0, len[0] ^ 1'b1}, 2);
            else if (len <= 13)
                put_bits(4'b1000 | (len - 6), 4);
            else if (len <= 28)
            begin
                put_bits(4'b1000, 4);
                put_bits(len - 13, 4);
            end
            else if (len <= 60)
            begin
                put_bits(9'b100000001, 9);
                put_bits(len - 29, 5);
            end
            else if (len <= 124)
            begin
                put_bits(10'b1000000001, 10);
                put_bits(len - 61, 6);
            end
            else
            begin
                put_bits(11'b10000000001, 11);
                put_bits(len - 125, 7);
            end
        end
        grow_prod(len);
    endfunction

    function automatic void enc_random_token();
        int unsigned r;
        int unsigned cdist;
        int unsigned len;
        r = $urandom_range(0, 99);
        if (enc_prod == 0 || r < 45 || r >= 97)
            enc_literal($urandom_range(0, 255));
        else if (r < 65)
            enc_word($urandom_range(1, (enc_prod < 862) ? enc_prod : 862));
        else
        begin
            if ($urandom_range(0, 9) < 7)
                cdist = $urandom_range(1, (enc_prod < 64) ? enc_prod : 64);
            else
                cdist = $urandom_range(1, (enc_prod < 57312) ? enc_prod : 57312);
            r = $urandom_range(0, 99);
            if (r < 40) len = $urandom_range(3, 4);
            else if (r < 80) len = $urandom_range(5, 28);
            else if (r < 95) len = $urandom_range(29, 252);
            else len = $urandom_range(0, 300);
            enc_block(cdist, len, r >= 95);
        end
    endfunction

    // every request is also run through decoder copy 1 so the plan avoids overfilling, but for the overfill close
    task automatic plan(input bit k, input logic [7:0] b, input bit last);
        request_t it;
        bit has;
        logic [7:0] ob;
        logic [1:0] st;
        it.k = k;
        it.b = b;
        it.last = last;
        stim_q.push_back(it);
        unpack_step(1, k, b, last, has, ob, st);
    endtask

    task automatic plan_byte(input bit last_ok);
        logic [7:0] b;
        b = 8'h00;
        for (int i = 7; i >= 0; i--)
            if (enc_bits.size() != 0)
                b[i] = enc_bits.pop_front();
        plan(1'b0, b, last_ok && enc_bits.size() == 0);
    endtask

    task automatic build_stream();
        int n;
        // directed opening: byte extremes, word and block copies, long and zero lengths
        enc_literal(8'h00);
        enc_literal(8'hff);
        enc_literal(8'ha5);
        enc_word(1);
        enc_block(2, 3, 0);
        enc_block(3, 4, 0);
        enc_block(1, 300, 1);
        enc_word(40);
        enc_word(200);
        enc_word(800);
        enc_block(100, 5, 0);
        enc_block(500, 0, 1);
        enc_block(1500, 6, 0);
        enc_block(3000, 20, 0);
        enc_block(6000, 45, 0);
        enc_block(9000, 100, 0);
        enc_block(16000, 200, 0);
        n = 0;
        while (n < N_ITEMS)
        begin
            if (d_rem[1] != 0)
                plan(1'b1, 8'h00, 1'b0);
            else
            begin
                while (enc_bits.size() < 16)
                    enc_random_token();
                if (d_cnt[1] <= 24 && $urandom_range(0, 99) < 50)
                    plan_byte(1'b0);
                else
                    plan(1'b1, 8'h00, 1'b0);
            end
            n++;
        end
        // close the stream one of four ways
        term_mode = $urandom_range(TERM_END, TERM_STARVE);
        case (term_mode)
            TERM_END: enc_end();
            TERM_BAD_DIST: enc_block((enc_prod < 57312) ? enc_prod + 1 : 57312, 3, 0);
            TERM_OVERFILL: put_bits($urandom, 32);
            default: put_bits(4'b0101, 4);
        endcase
        while (enc_bits.size() != 0)
        begin
            if (d_cnt[1] <= 24 || term_mode == TERM_OVERFILL)
                plan_byte(1'b1);
            else
                plan(1'b1, 8'h00, 1'b0);
        end
        n = 0;
        while (d_run[1] == RUN_OK && n < 100000)
        begin
            plan(1'b1, 8'h00, 1'b0);
            n++;
        end
        // late bytes are dropped, further pulls keep reporting the final state
        plan(1'b0, 8'h3c, 1'b0);
        plan(1'b1, 8'h00, 1'b0);
        plan(1'b0, 8'hc3, 1'b1);
        plan(1'b1, 8'h00, 1'b0);
        plan(1'b1, 8'h00, 1'b0);
    endtask

    // ---------------- idling ----------------

    // phase by requests accepted: none, sender idle, receiver stall, both
    function automatic bit roll_idle(input bit sender);
        int ph;
        ph = (acc_cnt / 350) % 4;
        if (ph == 3)
            return $urandom_range(0, 99) < 20;
        if ((sender && ph == 1) || (!sender && ph == 2))
            return $urandom_range(0, 99) < 48;
        return 0;
    endfunction

    // request driver; the accepted request is fed to decoder copy 0
    always @(posedge clk or negedge rst_n)
    begin : drv
        request_t it;
        bit has;
        logic [7:0] ob;
        logic [1:0] st;
        answer_t a;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            kind <= 1'b0;
            in_byte <= 8'h00;
            in_last <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                unpack_step(0, kind, in_byte, in_last, has, ob, st);
                if (has)
                begin
                    a.b = ob;
                    a.st = st;
                    expected_q.push_back(a);
                end
                acc_cnt++;
            end
            if (!in_valid || in_ready)
            begin
                if (stim_q.size() != 0 && !roll_idle(1'b1))
                begin
                    it = stim_q.pop_front();
                    in_valid <= 1'b1;
                    kind <= it.k;
                    in_byte <= it.b;
                    in_last <= it.last;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // one long receiver hold-off so the unpacker backs up into its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && acc_cnt >= 300)
        begin
            hold_left <= 600;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= (hold_left == 0) && !roll_idle(1'b0);
    end

    // result monitor
    always @(posedge clk)
    begin : mon
        answer_t a;
        if (rst_n && out_valid && out_ready)
        begin
            res_cnt++;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected result out_byte %02h status %0d", $time, out_byte, status);
                fail_cnt++;
            end
            else
            begin
                a = expected_q.pop_front();
                if (a.st !== status)
                begin
                    $display("%0t: status mismatch, expected %0d actual %0d", $time, a.st, status);
                    fail_cnt++;
                end
                if (a.b !== out_byte)
                begin
                    $display("%0t: out_byte mismatch, expected %02h actual %02h",
                             $time, a.b, out_byte);
                    fail_cnt++;
                end
            end
        end
    end

    initial
    begin
        #4000000;
        $display("timeout with %0d results outstanding", expected_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        acc_cnt = 0;
        res_cnt = 0;
        fail_cnt = 0;
        enc_prod = 0;
        model_clear(0);
        model_clear(1);
        build_stream();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        while (stim_q.size() != 0 || in_valid)
            @(posedge clk);
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("checked %0d results from %0d requests in one stream, %0d bytes decoded",
                 res_cnt, acc_cnt, d_prod[0]);
        $display("stream closed by case %0d (end code, bad distance, overfill, starved)",
                 term_mode);
        if (fail_cnt == 0 && expected_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
`default_nettype wire
